FILE: rtl/pgg_pkg.sv
// ----------------------------------------------------------------------------
// pgg_pkg
// Types and fixed constants of the polar Gaussian generator.
// ----------------------------------------------------------------------------
package pgg_pkg;

  localparam int IN_BITS  = 16;
  localparam int OUT_W    = 16;
  localparam int MUL_W    = 32;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int Y_W      = 31;
  localparam int FRAC_W   = 30;
  localparam int L_W      = 36;
  localparam int NP_W     = 32;
  localparam int Q_W      = 56;
  localparam int ROOT_W   = 28;
  localparam int REM_W    = 31;
  localparam int CNT_W    = 6;
  localparam int SH_W     = 8;

  localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;

  localparam logic [CNT_W-1:0] LOG_LAST  = CNT_W'(FRAC_W);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(Q_W - 1);
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(ROOT_W - 1);

  typedef struct packed {
    logic signed [IN_BITS-1:0] uniform_a;
    logic signed [IN_BITS-1:0] uniform_b;
  } in_beat_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] normal_sample;
    logic                    from_spare;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_A,
    ST_SQ_B,
    ST_SUM,
    ST_NORM,
    ST_LOG,
    ST_LN,
    ST_NPREP,
    ST_DIV,
    ST_SQRT,
    ST_MUL_A,
    ST_MUL_B,
    ST_SPARE,
    ST_EMIT
  } state_t;

endpackage

FILE: rtl/pgg_scale.sv
// ----------------------------------------------------------------------------
// pgg_scale
// Scale a product magnitude by a signed power of two, round half up,
// saturate and apply the sign.
// ----------------------------------------------------------------------------
module pgg_scale (
  input  logic [pgg_pkg::PROD_W-1:0]      prod,
  input  logic                            neg,
  input  logic signed [pgg_pkg::SH_W-1:0] shift_amt,
  output logic [pgg_pkg::OUT_W-1:0]       result
);

  logic [pgg_pkg::PROD_W-1:0] lim;
  logic [pgg_pkg::PROD_W-1:0] t;
  logic [pgg_pkg::PROD_W-1:0] m;
  logic [pgg_pkg::SH_W-1:0]   k;
  logic [pgg_pkg::OUT_W-1:0]  m16;

  always_comb begin
    lim = neg ? pgg_pkg::PROD_W'(32768) : pgg_pkg::PROD_W'(32767);
    k   = '0;
    t   = '0;
    if (shift_amt < 0) begin
      k = pgg_pkg::SH_W'(-shift_amt);
      t = prod >> (k - pgg_pkg::SH_W'(1));
      m = (t + pgg_pkg::PROD_W'(1)) >> 1;
    end else if (shift_amt > 0) begin
      if (shift_amt >= 16 || prod > (lim >> shift_amt)) begin
        m = lim;
      end else begin
        m = prod << shift_amt;
      end
    end else begin
      m = prod;
    end
    if (m > lim) begin
      m = lim;
    end
    m16    = m[pgg_pkg::OUT_W-1:0];
    result = neg ? pgg_pkg::OUT_W'(-m16) : m16;
  end

endmodule

FILE: rtl/polar_gaussian_generator.sv
// ----------------------------------------------------------------------------
// polar_gaussian_generator
// Normal samples from uniform pairs by the polar method, computed with one
// shared multiplier, a bit-serial divider and a two-bit-per-cycle root.
// ----------------------------------------------------------------------------
//  channel | ports                         | beat
//  --------+-------------------------------+------------------------------
//  in      | in_valid, in_ready, in_data   | uniform_a, uniform_b
//  out     | out_valid, out_ready, out_data| normal_sample, from_spare
//
//  The work on a fresh pair is dominated by the 56-step divider, 31
//  squarings and 28 root steps; normalisation shifts out each leading
//  zero of the 32-bit sum of squares.
//  A beat that finds a spare goes from idle straight to emit; a rejected
//  pair returns to idle after the sum. One pair is in work at a time;
//  in_ready is high only when idle. A finished sample waits in its own
//  state while out_valid stays high. Reset clears the spare flag and the output valid.
// ----------------------------------------------------------------------------
module polar_gaussian_generator #(
  parameter int OUT_FRAC_BITS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pgg_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pgg_pkg::out_beat_t out_data
);

  localparam int IN_BITS = pgg_pkg::IN_BITS;
  localparam int S_W     = 2 * IN_BITS;
  localparam int Z_W     = $clog2(S_W);
  localparam int SH_BASE = OUT_FRAC_BITS - 24 - (IN_BITS - 1);

  pgg_pkg::state_t state_r, state_nxt;

  logic signed [IN_BITS-1:0]           va, vb;
  logic [IN_BITS-1:0]                  a_mag_r, b_mag_r;
  logic                                neg_a_r, neg_b_r;
  logic [pgg_pkg::PROD_W-1:0]          prod_r;
  logic [pgg_pkg::MUL_W-1:0]           mul_x, mul_y;
  logic [S_W-1:0]                      s_r, sum_w;
  logic [S_W+30:0]                     s_ext;
  logic                                reject;
  logic [Z_W-1:0]                      z_r, e_r;
  logic [pgg_pkg::Y_W-1:0]             m_r, y_cur, y_adj;
  logic [31:0]                         y_sq;
  logic [pgg_pkg::FRAC_W-1:0]          frac_r;
  logic [pgg_pkg::L_W-1:0]             l_val;
  logic [30:0]                         n_val;
  logic [pgg_pkg::NP_W-1:0]            np_val;
  logic [pgg_pkg::CNT_W-1:0]           cnt_r;
  logic [pgg_pkg::REM_W-1:0]           rem_r;
  logic [pgg_pkg::Q_W-1:0]             q_r;
  logic [pgg_pkg::ROOT_W-1:0]          root_r;
  logic [31:0]                         div_t, sq_t, sq_trial;
  logic                                div_ge, sq_ge;
  logic signed [pgg_pkg::SH_W-1:0]     shift_amt;
  logic [pgg_pkg::OUT_W-1:0]           scaled;
  logic [pgg_pkg::OUT_W-1:0]           res_r, spare_r;
  logic                                res_spare_r, spare_valid_r;
  logic                                out_valid_r, load_out;
  pgg_pkg::out_beat_t                  out_data_r;

  assign va = IN_BITS'(in_data.uniform_a);
  assign vb = IN_BITS'(in_data.uniform_b);

  assign sum_w  = s_r + prod_r[S_W-1:0];
  assign reject = (sum_w == '0) || (sum_w[S_W-1:S_W-2] != 2'b00);
  assign s_ext  = {s_r, 31'b0};

  assign y_sq  = prod_r[61:30];
  assign y_adj = y_sq[31] ? y_sq[31:1] : y_sq[30:0];
  assign y_cur = (cnt_r == '0) ? m_r : y_adj;

  assign l_val  = {pgg_pkg::L_W'(6'(e_r)) << pgg_pkg::FRAC_W}
                  - pgg_pkg::L_W'(frac_r);
  assign n_val  = prod_r[60:30];
  assign np_val = e_r[0] ? {n_val, 1'b0} : {1'b0, n_val};

  assign div_t  = {rem_r, q_r[pgg_pkg::Q_W-1]};
  assign div_ge = div_t >= {1'b0, m_r};

  assign sq_t     = {rem_r[29:0], q_r[pgg_pkg::Q_W-1 -: 2]};
  assign sq_trial = {2'b00, root_r, 2'b01};
  assign sq_ge    = sq_t >= sq_trial;

  assign shift_amt = pgg_pkg::SH_W'(e_r >> 1) + pgg_pkg::SH_W'(SH_BASE);

  always_comb begin
    case (state_r)
      pgg_pkg::ST_SQ_A: begin
        mul_x = 32'(a_mag_r);
        mul_y = 32'(a_mag_r);
      end
      pgg_pkg::ST_SQ_B: begin
        mul_x = 32'(b_mag_r);
        mul_y = 32'(b_mag_r);
      end
      pgg_pkg::ST_LOG: begin
        mul_x = 32'(y_cur);
        mul_y = 32'(y_cur);
      end
      pgg_pkg::ST_LN: begin
        mul_x = 32'(l_val[pgg_pkg::L_W-1:6]);
        mul_y = 32'(pgg_pkg::TWO_LN2_Q30);
      end
      pgg_pkg::ST_MUL_A: begin
        mul_x = 32'(a_mag_r);
        mul_y = 32'(root_r);
      end
      pgg_pkg::ST_MUL_B: begin
        mul_x = 32'(b_mag_r);
        mul_y = 32'(root_r);
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  pgg_scale u_scale (
    .prod      (prod_r),
    .neg       ((state_r == pgg_pkg::ST_MUL_B) ? neg_a_r : neg_b_r),
    .shift_amt (shift_amt),
    .result    (scaled)
  );

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      pgg_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = spare_valid_r ? pgg_pkg::ST_EMIT : pgg_pkg::ST_SQ_A;
        end
      end
      pgg_pkg::ST_SQ_A:  state_nxt = pgg_pkg::ST_SQ_B;
      pgg_pkg::ST_SQ_B:  state_nxt = pgg_pkg::ST_SUM;
      pgg_pkg::ST_SUM:   state_nxt = reject ? pgg_pkg::ST_IDLE : pgg_pkg::ST_NORM;
      pgg_pkg::ST_NORM: begin
        if (s_r[S_W-1]) begin
          state_nxt = pgg_pkg::ST_LOG;
        end
      end
      pgg_pkg::ST_LOG: begin
        if (cnt_r == pgg_pkg::LOG_LAST) begin
          state_nxt = pgg_pkg::ST_LN;
        end
      end
      pgg_pkg::ST_LN:    state_nxt = pgg_pkg::ST_NPREP;
      pgg_pkg::ST_NPREP: state_nxt = pgg_pkg::ST_DIV;
      pgg_pkg::ST_DIV: begin
        if (cnt_r == pgg_pkg::DIV_LAST) begin
          state_nxt = pgg_pkg::ST_SQRT;
        end
      end
      pgg_pkg::ST_SQRT: begin
        if (cnt_r == pgg_pkg::SQRT_LAST) begin
          state_nxt = pgg_pkg::ST_MUL_A;
        end
      end
      pgg_pkg::ST_MUL_A: state_nxt = pgg_pkg::ST_MUL_B;
      pgg_pkg::ST_MUL_B: state_nxt = pgg_pkg::ST_SPARE;
      pgg_pkg::ST_SPARE: state_nxt = pgg_pkg::ST_EMIT;
      pgg_pkg::ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = pgg_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pgg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pgg_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spare_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (state_r == pgg_pkg::ST_IDLE && in_valid && spare_valid_r) begin
        spare_valid_r <= 1'b0;
      end else if (state_r == pgg_pkg::ST_SPARE) begin
        spare_valid_r <= 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_x * mul_y;
    if (load_out) begin
      out_data_r.normal_sample <= res_r;
      out_data_r.from_spare    <= res_spare_r;
    end
    case (state_r)
      pgg_pkg::ST_IDLE: begin
        neg_a_r <= va[IN_BITS-1];
        neg_b_r <= vb[IN_BITS-1];
        a_mag_r <= va[IN_BITS-1] ? IN_BITS'(-va) : IN_BITS'(va);
        b_mag_r <= vb[IN_BITS-1] ? IN_BITS'(-vb) : IN_BITS'(vb);
        res_r       <= spare_r;
        res_spare_r <= 1'b1;
      end
      pgg_pkg::ST_SQ_B: s_r <= prod_r[S_W-1:0];
      pgg_pkg::ST_SUM: begin
        s_r <= sum_w;
        z_r <= '0;
      end
      pgg_pkg::ST_NORM: begin
        if (s_r[S_W-1]) begin
          m_r   <= s_ext[S_W+30 -: 31];
          e_r   <= z_r - Z_W'(1);
          cnt_r <= '0;
        end else begin
          s_r <= s_r << 1;
          z_r <= z_r + Z_W'(1);
        end
      end
      pgg_pkg::ST_LOG: begin
        if (cnt_r != '0) begin
          frac_r <= {frac_r[pgg_pkg::FRAC_W-2:0], y_sq[31]};
        end
        cnt_r <= cnt_r + pgg_pkg::CNT_W'(1);
      end
      pgg_pkg::ST_NPREP: begin
        rem_r <= pgg_pkg::REM_W'(np_val[pgg_pkg::NP_W-1:2]);
        q_r   <= {np_val[1:0], 54'b0};
        cnt_r <= '0;
      end
      pgg_pkg::ST_DIV: begin
        q_r <= {q_r[pgg_pkg::Q_W-2:0], div_ge};
        if (cnt_r == pgg_pkg::DIV_LAST) begin
          cnt_r  <= '0;
          root_r <= '0;
          rem_r  <= '0;
        end else begin
          cnt_r <= cnt_r + pgg_pkg::CNT_W'(1);
          rem_r <= div_ge ? pgg_pkg::REM_W'(div_t - {1'b0, m_r})
                          : div_t[pgg_pkg::REM_W-1:0];
        end
      end
      pgg_pkg::ST_SQRT: begin
        rem_r  <= sq_ge ? pgg_pkg::REM_W'(sq_t - sq_trial) : pgg_pkg::REM_W'(sq_t);
        root_r <= {root_r[pgg_pkg::ROOT_W-2:0], sq_ge};
        q_r    <= q_r << 2;
        cnt_r  <= cnt_r + pgg_pkg::CNT_W'(1);
      end
      pgg_pkg::ST_MUL_B: begin
        res_r       <= scaled;
        res_spare_r <= 1'b0;
      end
      pgg_pkg::ST_SPARE: spare_r <= scaled;
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == pgg_pkg::ST_IDLE)
    else $error("in_ready outside idle");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pgg_pkg::ST_DIV |-> rem_r < m_r)
    else $error("divider remainder not below divisor");

  a_spare_used: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && spare_valid_r
    |=> state_r == pgg_pkg::ST_EMIT && !spare_valid_r && res_spare_r)
    else $error("spare beat not taken");

  a_spare_set: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pgg_pkg::ST_SPARE |=> spare_valid_r)
    else $error("spare not held after fresh pair");

  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pgg_pkg::ST_EMIT && out_valid_r && !out_ready
    |=> state_r == pgg_pkg::ST_EMIT)
    else $error("result dropped while output stalled");
`endif

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for polar_gaussian_generator. Uniform pairs are driven
// in random bursts; a bit-exact predictor of the polar method computes each
// expected sample and the spare it keeps, and every output beat is compared
// with the oldest expected sample while the receiver stalls on its own.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int F = 15;
  localparam int FRAC_OUT = 12;
  localparam longint unsigned LN2X2 = 64'd1488522236;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  pgg_pkg::in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pgg_pkg::out_beat_t out_data;

  pgg_pkg::out_beat_t sample_q[$];
  bit held_spare;
  logic [15:0] held_value;
  int errors = 0;
  int beats_sent = 0;
  int samples_seen = 0;
  int spares_seen = 0;
  int hold_off = 0;
  int burst_left = 0;

  polar_gaussian_generator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] round_sat(longint unsigned mag, bit neg, int sh);
    longint unsigned lim, m;
    lim = neg ? 64'd32768 : 64'd32767;
    m = mag;
    if (sh < 0) begin
      if (-sh >= 64) m = 0;
      else m = (m + (64'd1 << (-sh - 1))) >> (-sh);
    end else if (sh > 0) begin
      if (sh >= 16 || m > (lim >> sh)) m = lim;
      else m <<= sh;
    end
    if (m > lim) m = lim;
    return neg ? 16'(17'h10000 - m) : 16'(m);
  endfunction

  // Predict the sample caused by one accepted pair, if any.
  task automatic predict_sample(pgg_pkg::in_beat_t b);
    longint unsigned a, c, s, m, y, frac, l, n, q, rem, r;
    bit na, nb;
    int p, e, h;
    pgg_pkg::out_beat_t o;
    if (held_spare) begin
      o.normal_sample = held_value;
      o.from_spare = 1'b1;
      sample_q.push_back(o);
      held_spare = 0;
      return;
    end
    na = b.uniform_a[15];
    nb = b.uniform_b[15];
    a = na ? 64'(17'h10000 - {1'b0, b.uniform_a}) : 64'(b.uniform_a[14:0]);
    c = nb ? 64'(17'h10000 - {1'b0, b.uniform_b}) : 64'(b.uniform_b[14:0]);
    s = a * a + c * c;
    if (s == 0 || s >= (64'd1 << (2 * F))) return;
    p = 63;
    while (s[p] == 1'b0) p--;
    e = 2 * F - p;
    m = (p >= 30) ? (s >> (p - 30)) : (s << (30 - p));
    y = m;
    frac = 0;
    for (int i = 0; i < 30; i++) begin
      y = (y * y) >> 30;
      frac <<= 1;
      if (y >= (64'd1 << 31)) begin
        y >>= 1;
        frac |= 1;
      end
    end
    l = (64'(2 * F) << 30) - ((64'(p) << 30) + frac);
    n = ((l >> 6) * LN2X2) >> 30;
    if (e % 2) begin
      n <<= 1;
      h = (e - 1) / 2;
    end else begin
      h = e / 2;
    end
    q = (n << 30) / m;
    rem = (n << 30) % m;
    for (int i = 0; i < 24; i++) begin
      rem <<= 1;
      q <<= 1;
      if (rem >= m) begin
        rem -= m;
        q |= 1;
      end
    end
    r = int_sqrt(q);
    o.normal_sample = round_sat(a * r, na, h - F + FRAC_OUT - 24);
    o.from_spare = 1'b0;
    sample_q.push_back(o);
    held_value = round_sat(c * r, nb, h - F + FRAC_OUT - 24);
    held_spare = 1;
  endtask

  // Send one beat, with bursts and random gaps between them.
  task automatic send_pair(logic [15:0] ua, logic [15:0] ub);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20)) @(negedge clk);
    end
    burst_left--;
    in_data.uniform_a = ua;
    in_data.uniform_b = ub;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_sample(in_data);
    beats_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain_samples();
    int guard = 0;
    while (sample_q.size() != 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    repeat (200) @(negedge clk);
  endtask

  task automatic test_directed();
    logic [15:0] vals[8] = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001,
                             16'hffff, 16'h4000, 16'hc000, 16'h0100};
    send_pair(16'h0000, 16'h0000);
    send_pair(16'h8000, 16'h8000);
    send_pair(16'h7fff, 16'h7fff);
    send_pair(16'h0001, 16'h0000);
    send_pair(16'h0000, 16'hffff);
    send_pair(16'h7fff, 16'h0000);
    send_pair(16'h1234, 16'h5678);
    send_pair(16'h8001, 16'h0000);
    send_pair(16'h0000, 16'h7ffe);
    for (int i = 0; i < 8; i++) send_pair(vals[i], vals[7 - i]);
    drain_samples();
  endtask

  task automatic test_random(int count);
    logic [15:0] ua, ub;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0: begin
          ua = 16'($urandom_range(0, 7)) - 16'd3;
          ub = 16'($urandom_range(0, 7)) - 16'd3;
        end
        1: begin
          ua = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
          ub = 16'($urandom);
        end
        2: begin
          ua = 16'($urandom_range(23000, 23200));
          ub = 16'($urandom_range(23000, 23200));
          if ($urandom_range(0, 1)) ua = -ua;
        end
        default: begin
          ua = 16'($urandom);
          ub = 16'($urandom);
        end
      endcase
      send_pair(ua, ub);
    end
  endtask

  task automatic test_backpressure();
    hold_off = 400;
    test_random(30);
    drain_samples();
  endtask

  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) < 60);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (sample_q.size() == 0) begin
        $error("unexpected beat: normal_sample %0d from_spare %0b",
               out_data.normal_sample, out_data.from_spare);
        errors++;
      end else begin
        pgg_pkg::out_beat_t exp_s;
        exp_s = sample_q.pop_front();
        if (out_data.normal_sample !== exp_s.normal_sample) begin
          $error("normal_sample: expected %0d actual %0d",
                 exp_s.normal_sample, out_data.normal_sample);
          errors++;
        end
        if (out_data.from_spare !== exp_s.from_spare) begin
          $error("from_spare: expected %0b actual %0b",
                 exp_s.from_spare, out_data.from_spare);
          errors++;
        end
        samples_seen++;
        if (out_data.from_spare) spares_seen++;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random(700);
    drain_samples();
    test_backpressure();
    test_random(700);
    drain_samples();
    $display("Sent %0d pairs, checked %0d samples (%0d spares), with stalls",
             beats_sent, samples_seen, spares_seen);
    $display("and a long receiver hold-off that backed up the input.");
    if (errors == 0 && sample_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
